/* rtl/pefq_pkg.sv */
// Shared constants, payload types and derived limits of the error-feedback requantiser.
// No dependencies; the interfaces and every module import this package.
`default_nettype none

package pefq_pkg;

	// format of the datapath
	localparam int OUT_BITS  = 16;
	localparam int FRAC_BITS = 28;
	localparam int SMP_W     = 32;
	localparam int PCM_W     = 16;
	localparam int CNT_W     = 32;
	localparam int PEAK_W    = 31;
	localparam int DROP_BITS = FRAC_BITS + 1 - OUT_BITS;
	localparam int EXT_W     = SMP_W + 2;

	// lanes: left first, then right
	localparam int LANES    = 2;
	localparam int LANE_L   = 0;
	localparam int LANE_R   = 1;
	localparam int CLIP_N_W = $clog2(LANES + 1);

	// output queue
	localparam int OQ_DEPTH = 3;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic signed [EXT_W-1:0] Q_ONE      = EXT_W'(longint'(1) << FRAC_BITS);
	localparam logic signed [EXT_W-1:0] NEG_Q_ONE  = EXT_W'(-(longint'(1) << FRAC_BITS));
	localparam logic signed [EXT_W-1:0] CLIP_HI    = EXT_W'((longint'(1) << FRAC_BITS) - 1);
	localparam logic signed [EXT_W-1:0] ERR_HI_OFS =
		EXT_W'((longint'(1) << FRAC_BITS) - (longint'(1) << DROP_BITS));
	localparam logic signed [EXT_W-1:0] ERR_MAX    = EXT_W'((longint'(1) << (SMP_W - 1)) - 1);
	localparam logic signed [EXT_W-1:0] ERR_MIN    = EXT_W'(-(longint'(1) << (SMP_W - 1)));
	localparam logic signed [EXT_W-1:0] PEAK_MAX_X = EXT_W'((longint'(1) << PEAK_W) - 1);

	localparam logic signed [SMP_W-1:0] ERR_LIM     = SMP_W'(longint'(1) << (OUT_BITS - 1));
	localparam logic signed [SMP_W-1:0] NEG_ERR_LIM = SMP_W'(-(longint'(1) << (OUT_BITS - 1)));

	localparam logic signed [OUT_BITS-1:0] LVL_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
	localparam logic signed [OUT_BITS-1:0] LVL_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

	// what one lane found for its channel
	typedef struct packed {
		logic signed [PCM_W-1:0] pcm;
		logic                    clip;
		logic                    peak_ok;
		logic [PEAK_W-1:0]       excess;
	} lane_res_t;

	// one result beat
	typedef struct packed {
		logic signed [PCM_W-1:0] left_pcm;
		logic signed [PCM_W-1:0] right_pcm;
		logic [CNT_W-1:0]        clip_total;
		logic [PEAK_W-1:0]       clip_peak;
	} pcm_beat_t;

endpackage

`default_nettype wire

/* rtl/pefq_if.sv */
// Valid/ready channel interfaces: sample pairs in, PCM results out.
// Depends on pefq_pkg for field widths.
`default_nettype none

interface pefq_smp_if;
	import pefq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] left_sample;
	logic signed [SMP_W-1:0] right_sample;
	logic                    stereo;
	logic                    frame_start;
	logic                    restart;

	modport source (output valid, left_sample, right_sample, stereo, frame_start, restart,
		input ready);
	modport sink (input valid, left_sample, right_sample, stereo, frame_start, restart,
		output ready);
endinterface

interface pefq_pcm_if;
	import pefq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [PCM_W-1:0] left_pcm;
	logic signed [PCM_W-1:0] right_pcm;
	logic [CNT_W-1:0]        clip_total;
	logic [PEAK_W-1:0]       clip_peak;

	modport source (output valid, left_pcm, right_pcm, clip_total, clip_peak, input ready);
	modport sink (input valid, left_pcm, right_pcm, clip_total, clip_peak, output ready);
endinterface

`default_nettype wire

/* rtl/pefq_lane.sv */
// One channel lane: error feedback, clip to [-1, 1), truncation and the channel's error register.
// Depends on pefq_pkg.
`default_nettype none

module pefq_lane import pefq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    active,
	input  logic                    restart,
	input  logic signed [SMP_W-1:0] sample,
	output lane_res_t               res
);

	logic signed [SMP_W-1:0]          err_q;
	logic signed [SMP_W-1:0]          err_eff;
	logic signed [SMP_W-1:0]          err_new;
	logic signed [EXT_W-1:0]          sum;
	logic signed [EXT_W-1:0]          e_sel;
	logic signed [EXT_W-1:0]          x_sel;
	logic                             hi;
	logic                             lo;
	logic                             eligible;
	logic signed [OUT_BITS-1:0]       level;
	logic [OUT_BITS+PCM_W-1:0]        lvl_ext;
	logic [PEAK_W-1:0]                x_sat;

	always_comb begin
		err_eff = restart ? '0 : err_q;
		sum     = EXT_W'(sample) + EXT_W'(err_eff);
		hi      = sum >= Q_ONE;
		lo      = sum < NEG_Q_ONE;

		priority if (hi) begin
			level = LVL_MAX;
			e_sel = sum - ERR_HI_OFS;
			x_sel = sum - CLIP_HI;
		end else if (lo) begin
			level = LVL_MIN;
			e_sel = sum + Q_ONE;
			x_sel = NEG_Q_ONE - sum;
		end else begin
			// in range: the dropped low bits are the new error
			level = sum[DROP_BITS +: OUT_BITS];
			e_sel = {{(EXT_W - DROP_BITS){1'b0}}, sum[DROP_BITS-1:0]};
			x_sel = '0;
		end

		if (e_sel > ERR_MAX) begin
			err_new = ERR_MAX[SMP_W-1:0];
		end else if (e_sel < ERR_MIN) begin
			err_new = ERR_MIN[SMP_W-1:0];
		end else begin
			err_new = e_sel[SMP_W-1:0];
		end

		x_sat    = (x_sel > PEAK_MAX_X) ? '1 : x_sel[PEAK_W-1:0];
		eligible = (err_eff > NEG_ERR_LIM) && (err_eff < ERR_LIM);
		lvl_ext  = {{PCM_W{level[OUT_BITS-1]}}, level};

		res.pcm     = active ? lvl_ext[PCM_W-1:0] : '0;
		res.clip    = active && (hi || lo);
		res.peak_ok = active && (hi || lo) && eligible;
		res.excess  = x_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
		end else if (en) begin
			if (active) begin
				err_q <= err_new;
			end else if (restart) begin
				err_q <= '0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// an unclipped sample leaves only the truncated low bits behind
	a_small_err: assert property (@(posedge clk) disable iff (!arst_n)
		(en && active && !(hi || lo)) |=> (err_q[SMP_W-1:DROP_BITS] == '0))
		else $error("lane error wider than the dropped bits after an unclipped sample");
`endif

endmodule

`default_nettype wire

/* rtl/pefq_merge.sv */
// Merge stage: combines the lanes' clip flags and excesses into the clip count and frame peak.
// Depends on pefq_pkg.
`default_nettype none

module pefq_merge import pefq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      restart,
	input  logic      frame_start,
	input  lane_res_t res [LANES],
	output pcm_beat_t beat
);

	logic [CNT_W-1:0]    cnt_q;
	logic [PEAK_W-1:0]   peak_q;
	logic [CNT_W-1:0]    cnt_base;
	logic [CNT_W:0]      cnt_sum;
	logic [CNT_W-1:0]    cnt_new;
	logic [CLIP_N_W-1:0] nclip;
	logic [PEAK_W-1:0]   pk_new;

	always_comb begin
		nclip  = '0;
		pk_new = frame_start ? '0 : peak_q;
		// left before right; the max does not care
		for (int i = 0; i < LANES; i++) begin
			nclip = nclip + CLIP_N_W'(res[i].clip);
			if (res[i].peak_ok && (res[i].excess > pk_new)) begin
				pk_new = res[i].excess;
			end
		end
		cnt_base = restart ? '0 : cnt_q;
		cnt_sum  = (CNT_W + 1)'(cnt_base) + (CNT_W + 1)'(nclip);
		cnt_new  = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];

		beat.left_pcm   = res[LANE_L].pcm;
		beat.right_pcm  = res[LANE_R].pcm;
		beat.clip_total = cnt_new;
		beat.clip_peak  = pk_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			peak_q <= '0;
		end else if (en) begin
			cnt_q  <= cnt_new;
			peak_q <= pk_new;
		end
	end

`ifndef NO_ASSERTIONS
	// saturating count never goes down unless restarted
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !restart) |=> (cnt_q >= $past(cnt_q)))
		else $error("clip count fell without a restart");
`endif

endmodule

`default_nettype wire

/* rtl/pefq_outq.sv */
// Three-entry output queue driving the PCM result channel.
// Depends on pefq_pkg and pefq_pcm_if.
`default_nettype none

module pefq_outq import pefq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pcm_beat_t           din,
	pefq_pcm_if.source          pcm,
	output logic [OQ_CNT_W-1:0] count
);

	pcm_beat_t           mem [OQ_DEPTH];
	pcm_beat_t           head;
	logic [OQ_PTR_W-1:0] wr_q;
	logic [OQ_PTR_W-1:0] rd_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;

	function automatic logic [OQ_PTR_W-1:0] ptr_inc(input logic [OQ_PTR_W-1:0] p);
		return (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head           = mem[rd_q];
	assign pcm.valid      = count_q != '0;
	assign pcm.left_pcm   = head.left_pcm;
	assign pcm.right_pcm  = head.right_pcm;
	assign pcm.clip_total = head.clip_total;
	assign pcm.clip_peak  = head.clip_peak;
	assign pop            = pcm.valid && pcm.ready;
	assign count          = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q != OQ_CNT_W'(OQ_DEPTH)))
		else $error("output queue written while full");
`endif

endmodule

`default_nettype wire

/* rtl/pcm_error_feedback_quantizer.sv */
// Error-feedback requantiser, Q4.28 sample pairs to 16-bit PCM: two channel lanes, merge, queue.
// Depends on pefq_pkg, pefq_if, pefq_lane, pefq_merge and pefq_outq.
//
// Usage
//  smp : sink of sample-pair beats (left_sample, right_sample, stereo, frame_start, restart).
//  pcm : source of result beats (left_pcm, right_pcm, clip_total, clip_peak); left_pcm is
//        packed first. right_pcm is zero for a mono beat.
//  Path: a taken beat is held in the lane stage register, then written to the output queue,
//        and shows on pcm from then on until the receiver, when ready, takes it.
//  Throughput: one beat per cycle while the output queue has room. The error loop (sample
//        plus carried error, clip, truncate) closes inside each lane into its error register;
//        clip count and frame peak are updated in the merge stage from the lane stage register.
//  Stall: results collect in a 3-entry queue. smp.ready is taken from registered state only
//        and drops once the queue plus the beat in the lane stage would fill it. With pcm.ready
//        high beats flow at full rate; a receiver stall backs up into smp.ready, and nothing
//        is lost under a long stall.
//  Reset (arst_n low): both error registers, the clip count and the peak clear, and the
//        pipeline and queue empty. restart on a beat clears errors and count before that beat
//        is processed; frame_start clears the peak likewise.
`default_nettype none

module pcm_error_feedback_quantizer import pefq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pefq_smp_if.sink   smp,
	pefq_pcm_if.source pcm
);

	logic                    accept;
	logic [OQ_CNT_W-1:0]     oq_count;
	logic [OQ_CNT_W:0]       in_flight;
	logic signed [SMP_W-1:0] lane_smp [LANES];
	logic                    lane_act [LANES];
	lane_res_t               lane_res [LANES];

	// lane stage register
	logic                    valid_s1;
	lane_res_t               res_s1 [LANES];
	logic                    restart_s1;
	logic                    frame_start_s1;

	pcm_beat_t               merged;

	// room check counts the beat held in the lane stage as already queued
	assign in_flight = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(valid_s1);
	assign smp.ready = in_flight < (OQ_CNT_W + 1)'(OQ_DEPTH);
	assign accept    = smp.valid && smp.ready;

	always_comb begin
		lane_smp[LANE_L] = smp.left_sample;
		lane_smp[LANE_R] = smp.right_sample;
		lane_act[LANE_L] = 1'b1;
		lane_act[LANE_R] = smp.stereo;
	end

	// one requantiser per channel, side by side
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		pefq_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (accept),
			.active  (lane_act[i]),
			.restart (smp.restart),
			.sample  (lane_smp[i]),
			.res     (lane_res[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1         <= lane_res;
			restart_s1     <= smp.restart;
			frame_start_s1 <= smp.frame_start;
		end
	end

	pefq_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (valid_s1),
		.restart     (restart_s1),
		.frame_start (frame_start_s1),
		.res         (res_s1),
		.beat        (merged)
	);

	// the lane stage always drains: room was reserved when the beat was taken
	pefq_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.din    (merged),
		.pcm    (pcm),
		.count  (oq_count)
	);

`ifndef NO_ASSERTIONS
	a_s1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat missing from the lane stage");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (oq_count != OQ_CNT_W'(OQ_DEPTH) || (pcm.valid && pcm.ready)))
		else $error("lane stage beat with no room in the output queue");
`endif

endmodule

`default_nettype wire

/* dv/pcm_error_feedback_quantizer_test.sv */
// Self-checking bench for pcm_error_feedback_quantizer: sample-pair beats in, PCM result beats out.
// Depends on pefq_pkg, pefq_if and the RTL; scoreboard class and stimulus tasks live here.
`timescale 1ns / 1ps

import pefq_pkg::*;

class pcm_scoreboard;
	logic signed [SMP_W-1:0] err_left;
	logic signed [SMP_W-1:0] err_right;
	logic [CNT_W-1:0]        clip_count;
	logic [PEAK_W-1:0]       frame_peak;
	pcm_beat_t               expected_beats[$];
	int mismatches, beats_in, beats_out, clip_events, mono_beats, restarts;

	function new();
		err_left    = '0;
		err_right   = '0;
		clip_count  = '0;
		frame_peak  = '0;
		mismatches  = 0;
		beats_in    = 0;
		beats_out   = 0;
		clip_events = 0;
		mono_beats  = 0;
		restarts    = 0;
	endfunction

	task report(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// sum with carried error, clip to [-1, 1), truncate toward minus infinity
	function logic signed [PCM_W-1:0] requantise(input logic signed [SMP_W-1:0] smp_in,
			inout logic signed [SMP_W-1:0] err);
		logic signed [EXT_W-1:0] sum, clipped, excess, mag, lvl, quant, resid;
		sum = smp_in;
		sum = sum + err;
		mag = err;
		if (mag < 0)
			mag = -mag;
		clipped = sum;
		excess  = '0;
		if (sum >= Q_ONE) begin
			clipped = CLIP_HI;
			excess  = sum - CLIP_HI;
		end else if (sum < NEG_Q_ONE) begin
			clipped = NEG_Q_ONE;
			excess  = NEG_Q_ONE - sum;
		end
		if (clipped != sum) begin
			clip_events++;
			if (clip_count != '1)
				clip_count++;
			if (excess > PEAK_MAX_X)
				excess = PEAK_MAX_X;
			// peak only follows while the carried error is small
			if (excess > $signed(EXT_W'(frame_peak)) && mag < ERR_LIM)
				frame_peak = excess[PEAK_W-1:0];
		end
		lvl   = ((clipped + Q_ONE) >>> DROP_BITS) - ERR_LIM;
		quant = lvl <<< DROP_BITS;
		resid = sum - quant;
		if (resid > ERR_MAX)
			resid = ERR_MAX;
		else if (resid < ERR_MIN)
			resid = ERR_MIN;
		err = resid[SMP_W-1:0];
		return lvl[PCM_W-1:0];
	endfunction

	function void note_sample(input logic signed [SMP_W-1:0] l, r, input logic st, fs, rs);
		pcm_beat_t want;
		beats_in++;
		if (rs) begin
			err_left   = '0;
			err_right  = '0;
			clip_count = '0;
			restarts++;
		end
		if (fs)
			frame_peak = '0;
		want.left_pcm  = requantise(l, err_left);
		want.right_pcm = '0;
		if (st)
			want.right_pcm = requantise(r, err_right);
		else
			mono_beats++;
		want.clip_total = clip_count;
		want.clip_peak  = frame_peak;
		expected_beats.push_back(want);
	endfunction

	task check_result(input pcm_beat_t got);
		pcm_beat_t want;
		beats_out++;
		if (expected_beats.size() == 0) begin
			report($sformatf("result beat with nothing pending (left %0d right %0d)",
				got.left_pcm, got.right_pcm));
			return;
		end
		want = expected_beats.pop_front();
		if (got.left_pcm !== want.left_pcm)
			report($sformatf("left_pcm %0d, want %0d", got.left_pcm, want.left_pcm));
		if (got.right_pcm !== want.right_pcm)
			report($sformatf("right_pcm %0d, want %0d", got.right_pcm, want.right_pcm));
		if (got.clip_total !== want.clip_total)
			report($sformatf("clip_total %0d, want %0d", got.clip_total, want.clip_total));
		if (got.clip_peak !== want.clip_peak)
			report($sformatf("clip_peak 0x%h, want 0x%h", got.clip_peak, want.clip_peak));
	endtask
endclass

module pcm_error_feedback_quantizer_test;

	localparam int RANDOM_BEATS = 1900;
	localparam int IDLE_LIMIT   = 1000;   // cycles without any beat before giving up
	localparam int DRAIN_CYCLES = 10;     // pipeline is two deep; a little margin on top

	localparam logic signed [SMP_W-1:0] S_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [SMP_W-1:0] S_MIN  = 32'sh8000_0000;
	localparam logic signed [SMP_W-1:0] S_ONE  = 32'sh1000_0000;   // 1.0 in Q4.28

	logic clk;
	logic arst_n;

	pefq_smp_if smp ();
	pefq_pcm_if pcm ();

	pcm_error_feedback_quantizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.pcm    (pcm)
	);

	pcm_scoreboard sb = new();

	bit tx_quiet;      // sender runs without gaps while set
	bit rx_quiet;      // receiver never stalls while set
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Sample mix: mostly in range, plenty near and past the clip limits,
	// some full-scale words so every input bit toggles.
	function automatic logic signed [SMP_W-1:0] rand_sample();
		logic signed [SMP_W-1:0] s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: s = $signed($urandom_range(0, 32'h1FFF_FFFF)) - S_ONE;
			5: begin
				if ($urandom_range(0, 1))
					s = S_ONE - $signed($urandom_range(0, 16));
				else
					s = -S_ONE + $signed($urandom_range(0, 16)) - 32'sd8;
			end
			6: s = $urandom();
			7: s = $urandom_range(0, 1) ? S_MAX : S_MIN;
			8: begin
				s = $signed($urandom_range(32'h1000_0000, 32'h3FFF_FFFF));
				if ($urandom_range(0, 1))
					s = -s;
			end
			default: s = $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh8000;
		endcase
		return s;
	endfunction

	// Present one sample-pair beat and hold it until the block takes it.
	task automatic send_pair(input logic signed [SMP_W-1:0] l, r, input logic st, fs, rs);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			smp.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.valid        = 1'b1;
		smp.left_sample  = l;
		smp.right_sample = r;
		smp.stereo       = st;
		smp.frame_start  = fs;
		smp.restart      = rs;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		sb.note_sample(l, r, st, fs, rs);
		@(negedge clk);
	endtask

	// Receiver: ready toggled at the falling edge, with quiet stretches now and then.
	initial begin
		int hold;
		int stretch;
		pcm.ready = 1'b0;
		hold      = 0;
		stretch   = 0;
		rx_quiet  = 1'b0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch  = $urandom_range(50, 300);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			if (hold > 0) begin
				pcm.ready = 1'b0;
				hold--;
			end else begin
				pcm.ready = 1'b1;
				hold      = pick_gap(rx_quiet);
			end
		end
	end

	// Result beats are checked at the rising edge they are taken.
	always @(posedge clk) begin
		pcm_beat_t got;
		if (arst_n && pcm.valid && pcm.ready) begin
			got.left_pcm   = pcm.left_pcm;
			got.right_pcm  = pcm.right_pcm;
			got.clip_total = pcm.clip_total;
			got.clip_peak  = pcm.clip_peak;
			sb.check_result(got);
		end
	end

	// Watchdog: too long without a beat on either side means the block has hung.
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (pcm.valid && pcm.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d cycles without a beat, %0d results outstanding",
				idle_cycles, sb.expected_beats.size());
			$display("pcm_error_feedback_quantizer_test: FAIL");
			$finish;
		end
	end

	initial begin
		int seg_left;
		logic st, fs, rs;

		arst_n           = 1'b0;
		tx_quiet         = 1'b0;
		smp.valid        = 1'b0;
		smp.left_sample  = '0;
		smp.right_sample = '0;
		smp.stereo       = 1'b0;
		smp.frame_start  = 1'b0;
		smp.restart      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part.
		send_pair('0, '0, 1'b1, 1'b1, 1'b1);
		// full scale both ways: clip, then huge carried error saturates and
		// the excess passes the peak ceiling; peak stops following
		send_pair(S_MAX, S_MIN, 1'b1, 1'b0, 1'b0);
		send_pair(S_MAX, S_MIN, 1'b1, 1'b0, 1'b0);
		send_pair(S_MAX, S_MIN, 1'b1, 1'b0, 1'b0);
		// restart without frame_start keeps the peak; exact clip limits
		send_pair(S_ONE - 32'sd1, -S_ONE, 1'b1, 1'b0, 1'b1);
		send_pair(S_ONE, -S_ONE - 32'sd1, 1'b1, 1'b1, 1'b0);
		// mono: right sample ignored, right error untouched
		send_pair(S_MAX, S_MAX, 1'b0, 1'b0, 1'b0);
		send_pair(32'shAAAA_AAAA, 32'sh5555_5555, 1'b1, 1'b0, 1'b1);
		send_pair(32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 1'b0, 1'b0);
		send_pair(32'sd1, -32'sd1, 1'b1, 1'b1, 1'b1);
		send_pair(32'sh0000_1FFF, -32'sh2000, 1'b1, 1'b0, 1'b0);
		send_pair(S_MIN, S_MIN, 1'b0, 1'b0, 1'b0);
		send_pair(S_MIN, S_MIN, 1'b1, 1'b0, 1'b0);
		send_pair(-S_ONE, S_ONE - 32'sd1, 1'b0, 1'b1, 1'b1);
		send_pair('0, '0, 1'b0, 1'b0, 1'b0);
		send_pair(32'sh0FFF_E000, 32'shF000_2000, 1'b1, 1'b0, 1'b0);
		send_pair(S_MAX, S_MAX, 1'b1, 1'b1, 1'b1);

		// Random part, in stretches that switch the sender's gaps on and off.
		seg_left = 0;
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 150);
				tx_quiet = ($urandom_range(0, 4) == 0);
			end
			seg_left--;
			st = ($urandom_range(0, 3) != 0);
			fs = ($urandom_range(0, 29) == 0);
			rs = ($urandom_range(0, 39) == 0);
			send_pair(rand_sample(), rand_sample(), st, fs, rs);
		end
		smp.valid = 1'b0;

		while (sb.expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d sample beats (%0d mono, %0d with restart), %0d clipped samples",
			sb.beats_in, sb.mono_beats, sb.restarts, sb.clip_events);
		$display("checked %0d result beats, %0d mismatches", sb.beats_out, sb.mismatches);
		if (sb.mismatches == 0)
			$display("pcm_error_feedback_quantizer_test: PASS");
		else
			$display("pcm_error_feedback_quantizer_test: FAIL");
		$finish;
	end

endmodule
